[src/mmwp_pkg.sv]
// ============================================================================
// mmwp_pkg
// Shared constants and functions for the mean-max window power block.
// ============================================================================
package mmwp_pkg;

    localparam int NUM_WINDOWS = 15;
    localparam int WIN_BITS    = 12;
    localparam int MEAN_BITS   = 16;
    localparam int START_BITS  = 14;
    localparam int IN_BITS     = 13;
    localparam int TIME_BITS   = 32;
    localparam int WIDX_BITS   = 4;

    // Window lengths in samples, shortest first.
    function automatic logic [WIN_BITS-1:0] win_len(input logic [WIDX_BITS-1:0] idx);
        logic [WIN_BITS-1:0] len;
        begin
            case (idx)
                4'd0:    len = 12'd3;
                4'd1:    len = 12'd5;
                4'd2:    len = 12'd10;
                4'd3:    len = 12'd20;
                4'd4:    len = 12'd30;
                4'd5:    len = 12'd45;
                4'd6:    len = 12'd60;
                4'd7:    len = 12'd180;
                4'd8:    len = 12'd300;
                4'd9:    len = 12'd600;
                4'd10:   len = 12'd900;
                4'd11:   len = 12'd1200;
                4'd12:   len = 12'd1800;
                4'd13:   len = 12'd2700;
                default: len = 12'd3600;
            endcase
            return len;
        end
    endfunction

endpackage

[src/mmwp_if.sv]
// ============================================================================
// mmwp_sample_if / mmwp_result_if
// Valid/ready channels for input samples and window results.
// ============================================================================
interface mmwp_sample_if;
    logic               valid;
    logic               ready;
    logic signed [12:0] sample_power;
    logic [31:0]        sample_time;
    logic               last_sample;
    modport source (output valid, sample_power, sample_time, last_sample, input ready);
    modport sink   (input valid, sample_power, sample_time, last_sample, output ready);
endinterface

interface mmwp_result_if;
    logic        valid;
    logic        ready;
    logic [11:0] window_seconds;
    logic [15:0] best_mean_x16;
    logic [13:0] best_start;
    logic        no_valid_power;
    logic        final_result;
    modport source (output valid, window_seconds, best_mean_x16, best_start,
                    no_valid_power, final_result, input ready);
    modport sink   (input valid, window_seconds, best_mean_x16, best_start,
                    no_valid_power, final_result, output ready);
endinterface

[src/mmwp_store.sv]
// ============================================================================
// mmwp_store
// Sample memory: one write port, two registered read ports.
// ============================================================================
module mmwp_store #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 12
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two registered read ports.
    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

[src/mmwp_divider.sv]
// ============================================================================
// mmwp_divider
// Window mean: 16 * sum / window length by reciprocal multiplication.
// ============================================================================
module mmwp_divider
    import mmwp_pkg::*;
#(
    parameter int SUM_BITS = 24,
    parameter int Q_BITS   = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SUM_BITS-1:0]  sum,
    input  logic [WIDX_BITS-1:0] widx,
    output logic                 done,
    output logic [Q_BITS-1:0]    quot
);

    // The dividend is 16 * sum, so it is NUM_BITS wide.
    localparam int NUM_BITS   = SUM_BITS + 4;
    localparam int RECIP_BITS = NUM_BITS + 2;
    localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
    localparam int SHIFT_BITS = $clog2(PROD_BITS);

    logic [RECIP_BITS-1:0] recip_tab [NUM_WINDOWS];
    logic [SHIFT_BITS-1:0] shift_tab [NUM_WINDOWS];
    logic [PROD_BITS-1:0]  prod_reg;
    logic [SHIFT_BITS-1:0] shift_reg;
    logic                  done_reg;

    // Reciprocal table: ceil(2^S / L) with S = NUM_BITS + ceil(log2 L).
    // The rounding error stays below 2^S for any dividend under 2^NUM_BITS,
    // so the floor of the product is the exact quotient.
    for (genvar k = 0; k < NUM_WINDOWS; k++)
    begin : g_recip
        localparam int LEN   = int'(win_len(WIDX_BITS'(k)));
        localparam int SHIFT = NUM_BITS + $clog2(LEN);
        assign recip_tab[k] = RECIP_BITS'(((64'd1 << SHIFT) + 64'(LEN - 1)) / 64'(LEN));
        assign shift_tab[k] = SHIFT_BITS'(SHIFT - 4);
    end

    // The product is registered; the quotient is valid while done is high and holds
    // until the next start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            prod_reg  <= '0;
            shift_reg <= '0;
        end
        else
        begin
            done_reg <= start;
            if (start)
            begin
                prod_reg  <= PROD_BITS'(sum) * PROD_BITS'(recip_tab[widx]);
                shift_reg <= shift_tab[widx];
            end
        end
    end

    assign done = done_reg;
    assign quot = Q_BITS'(prod_reg >> shift_reg);

endmodule

[src/mean_max_window_power.sv]
// ============================================================================
// mean_max_window_power
// Loads a record of power samples, then scans 15 window lengths for the
// highest window mean and its first start index.
// ============================================================================
//  channel | dir | payload
//  smp     | in  | sample_power, sample_time, last_sample
//  res     | out | window_seconds, best_mean_x16, best_start, no_valid_power,
//          |     | final_result
//
// Samples load at one per cycle, while ready is high, into the sample memory.
// After the final sample, for each fitting window the memory read ports walk
// the store once, then a reciprocal multiply forms the mean.
// A window that does not fit is skipped.
// No sample is accepted while the scan runs or a result waits.
// Reset clears all control state; the sample memory needs no clearing.
module mean_max_window_power
    import mmwp_pkg::*;
#(
    parameter int MAX_SAMPLES = 16384,
    parameter int POWER_BITS  = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    mmwp_sample_if.sink   smp,
    mmwp_result_if.source res
);

    localparam int ADDR_BITS = $clog2(MAX_SAMPLES);
    localparam int CNT_BITS  = ADDR_BITS + 1;
    localparam int SUM_BITS  = POWER_BITS + WIN_BITS;

    typedef enum logic [2:0] {
        ST_LOAD, ST_PICK, ST_FILL, ST_SLIDE, ST_DIV, ST_OUT, ST_DONE
    } state_t;

    state_t                 state_reg;
    logic [CNT_BITS-1:0]    count_reg;
    logic [TIME_BITS-1:0]   first_time_reg;
    logic [TIME_BITS-1:0]   latest_time_reg;
    logic [POWER_BITS-1:0]  held_reg;
    logic [CNT_BITS-1:0]    lead_reg;
    logic [POWER_BITS-1:0]  first_valid_reg;
    logic                   seen_valid_reg;
    logic                   seen_pos_reg;
    logic [WIDX_BITS-1:0]   widx_reg;
    logic                   any_reg;
    logic [CNT_BITS-1:0]    ptr_reg;
    logic                   pend_reg;
    logic                   pend_fill_reg;
    logic [CNT_BITS-1:0]    pend_add_idx_reg;
    logic [CNT_BITS-1:0]    pend_sub_idx_reg;
    logic [CNT_BITS-1:0]    pend_st_reg;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [SUM_BITS-1:0]    best_reg;
    logic [CNT_BITS-1:0]    best_st_reg;
    logic                   div_start_reg;
    logic                   res_valid_reg;
    logic [WIN_BITS-1:0]    res_win_reg;
    logic [MEAN_BITS-1:0]   res_mean_reg;
    logic [START_BITS-1:0]  res_start_reg;
    logic                   res_nov_reg;
    logic                   res_fin_reg;

    logic                   accept;
    logic                   missing;
    logic [POWER_BITS-1:0]  clipped;
    logic [POWER_BITS-1:0]  wr_val;
    logic                   wr_en;
    logic [ADDR_BITS-1:0]   rd_addr_a;
    logic [ADDR_BITS-1:0]   rd_addr_b;
    logic [POWER_BITS-1:0]  rd_data_a;
    logic [POWER_BITS-1:0]  rd_data_b;
    logic [POWER_BITS-1:0]  add_val;
    logic [POWER_BITS-1:0]  sub_val;
    logic [SUM_BITS-1:0]    sum_next;
    logic [TIME_BITS-1:0]   duration;
    logic [WIN_BITS-1:0]    cur_len;
    logic                   fits;
    logic                   div_done;
    logic [MEAN_BITS-1:0]   div_quot;
    logic [CNT_BITS-1:0]    sub_idx;

    assign accept    = smp.valid && smp.ready;
    assign smp.ready = (state_reg == ST_LOAD) && !res_valid_reg;
    assign missing   = smp.sample_power[IN_BITS-1];

    // Saturate the sample into the power range.
    always_comb
    begin
        if (smp.sample_power[IN_BITS-2:0] > (IN_BITS-1)'({POWER_BITS{1'b1}}))
        begin
            clipped = {POWER_BITS{1'b1}};
        end
        else
        begin
            clipped = POWER_BITS'(smp.sample_power[IN_BITS-2:0]);
        end
        wr_val = missing ? held_reg : clipped;
    end

    assign wr_en = accept && (count_reg < CNT_BITS'(MAX_SAMPLES));

    // Window selection and fit test.
    assign cur_len  = win_len(widx_reg);
    assign duration = (latest_time_reg >= first_time_reg) ?
                      (latest_time_reg - first_time_reg) : '0;
    assign fits     = (TIME_BITS'(cur_len) <= duration) &&
                      (CNT_BITS'(cur_len) <= count_reg);

    // Read addresses: port a brings in the new sample, port b drops the old.
    assign sub_idx   = ptr_reg - CNT_BITS'(cur_len);
    assign rd_addr_a = ptr_reg[ADDR_BITS-1:0];
    assign rd_addr_b = sub_idx[ADDR_BITS-1:0];

    // Leading missing samples read as the first valid power.
    assign add_val  = (pend_add_idx_reg < lead_reg) ? first_valid_reg : rd_data_a;
    assign sub_val  = (pend_sub_idx_reg < lead_reg) ? first_valid_reg : rd_data_b;
    assign sum_next = pend_fill_reg ? (sum_reg + SUM_BITS'(add_val))
                                    : (sum_reg + SUM_BITS'(add_val) - SUM_BITS'(sub_val));

    mmwp_store #(
        .DEPTH (MAX_SAMPLES),
        .WIDTH (POWER_BITS)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (count_reg[ADDR_BITS-1:0]),
        .wr_data   (wr_val),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    mmwp_divider #(
        .SUM_BITS (SUM_BITS),
        .Q_BITS   (MEAN_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .sum   (best_reg),
        .widx  (widx_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Record loading, window scan and result hand-off.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOAD;
            count_reg       <= '0;
            first_time_reg  <= '0;
            latest_time_reg <= '0;
            held_reg        <= '0;
            lead_reg        <= '0;
            first_valid_reg <= '0;
            seen_valid_reg  <= 1'b0;
            seen_pos_reg    <= 1'b0;
            widx_reg        <= '0;
            any_reg         <= 1'b0;
            ptr_reg         <= '0;
            pend_reg        <= 1'b0;
            pend_fill_reg   <= 1'b0;
            sum_reg         <= '0;
            best_reg        <= '0;
            best_st_reg     <= '0;
            div_start_reg   <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (res_valid_reg && res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (accept)
                    begin
                        if (wr_en)
                        begin
                            if (count_reg == '0)
                            begin
                                first_time_reg <= smp.sample_time;
                            end
                            latest_time_reg <= smp.sample_time;
                            if (!missing)
                            begin
                                if (!seen_valid_reg)
                                begin
                                    seen_valid_reg  <= 1'b1;
                                    first_valid_reg <= clipped;
                                end
                                if (clipped != '0)
                                begin
                                    seen_pos_reg <= 1'b1;
                                end
                                held_reg <= clipped;
                            end
                            else if (!seen_valid_reg)
                            begin
                                lead_reg <= count_reg + 1'b1;
                            end
                            count_reg <= count_reg + 1'b1;
                        end
                        if (smp.last_sample)
                        begin
                            widx_reg <= '0;
                            any_reg  <= 1'b0;
                            state_reg <= ST_PICK;
                        end
                    end
                end

                ST_PICK:
                begin
                    if (!seen_pos_reg)
                    begin
                        res_valid_reg <= 1'b1;
                        res_win_reg   <= '0;
                        res_mean_reg  <= '0;
                        res_start_reg <= '0;
                        res_nov_reg   <= 1'b1;
                        res_fin_reg   <= 1'b1;
                        state_reg     <= ST_DONE;
                    end
                    else if (fits)
                    begin
                        ptr_reg   <= '0;
                        sum_reg   <= '0;
                        pend_reg  <= 1'b0;
                        state_reg <= ST_FILL;
                    end
                    else if (widx_reg == WIDX_BITS'(NUM_WINDOWS - 1))
                    begin
                        if (!any_reg)
                        begin
                            res_valid_reg <= 1'b1;
                            res_win_reg   <= '0;
                            res_mean_reg  <= '0;
                            res_start_reg <= '0;
                            res_nov_reg   <= 1'b0;
                            res_fin_reg   <= 1'b1;
                        end
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        widx_reg <= widx_reg + 1'b1;
                    end
                end

                ST_FILL, ST_SLIDE:
                begin
                    // Absorb the data read in the previous cycle.
                    if (pend_reg)
                    begin
                        sum_reg <= sum_next;
                        if (!pend_fill_reg)
                        begin
                            if (sum_next > best_reg)
                            begin
                                best_reg    <= sum_next;
                                best_st_reg <= pend_st_reg;
                            end
                        end
                        else if (pend_add_idx_reg == CNT_BITS'(cur_len) - 1'b1)
                        begin
                            best_reg    <= sum_next;
                            best_st_reg <= '0;
                        end
                    end
                    // Issue the next read.
                    if (ptr_reg < count_reg)
                    begin
                        pend_reg         <= 1'b1;
                        pend_fill_reg    <= (ptr_reg < CNT_BITS'(cur_len));
                        pend_add_idx_reg <= ptr_reg;
                        pend_sub_idx_reg <= sub_idx;
                        pend_st_reg      <= sub_idx + 1'b1;
                        ptr_reg          <= ptr_reg + 1'b1;
                        state_reg        <= (ptr_reg + 1'b1 < CNT_BITS'(cur_len)) ?
                                            ST_FILL : ST_SLIDE;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (!pend_reg)
                        begin
                            div_start_reg <= 1'b1;
                            state_reg     <= ST_DIV;
                        end
                    end
                end

                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_OUT;
                    end
                end

                ST_OUT:
                begin
                    // The result registers load only once the previous item has left.
                    if (!res_valid_reg)
                    begin
                        any_reg       <= 1'b1;
                        res_valid_reg <= 1'b1;
                        res_mean_reg  <= div_quot;
                        res_win_reg   <= cur_len;
                        res_start_reg <= START_BITS'(best_st_reg);
                        res_nov_reg   <= 1'b0;
                        // Last window in the list, or no later window fits.
                        res_fin_reg   <= (widx_reg == WIDX_BITS'(NUM_WINDOWS - 1)) ||
                                         (TIME_BITS'(win_len(widx_reg + 1'b1)) > duration) ||
                                         (CNT_BITS'(win_len(widx_reg + 1'b1)) > count_reg);
                        if (widx_reg == WIDX_BITS'(NUM_WINDOWS - 1))
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            widx_reg  <= widx_reg + 1'b1;
                            state_reg <= ST_PICK;
                        end
                    end
                end

                ST_DONE:
                begin
                    if (!res_valid_reg)
                    begin
                        count_reg       <= '0;
                        first_time_reg  <= '0;
                        latest_time_reg <= '0;
                        held_reg        <= '0;
                        lead_reg        <= '0;
                        first_valid_reg <= '0;
                        seen_valid_reg  <= 1'b0;
                        seen_pos_reg    <= 1'b0;
                        state_reg       <= ST_LOAD;
                    end
                end

                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.window_seconds = res_win_reg;
    assign res.best_mean_x16  = res_mean_reg;
    assign res.best_start     = res_start_reg;
    assign res.no_valid_power = res_nov_reg;
    assign res.final_result   = res_fin_reg;

endmodule
